// File: design/two_class_priority_queue_unit_macros.svh
// assertion helpers shared by the queue modules
`ifndef TWO_CLASS_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define TWO_CLASS_PRIORITY_QUEUE_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge out of reset
`define TCPQ_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition must never be seen at a clock edge out of reset
`define TCPQ_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define TCPQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define TCPQ_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

// File: design/tcpq_pkg.sv
package tcpq_pkg;

	typedef logic signed [31:0] word_t;
	typedef logic [1:0] code_t;

	// request codes
	localparam code_t REQ_ENQ  = 2'd0;
	localparam code_t REQ_PRIO = 2'd1;
	localparam code_t REQ_DEQ  = 2'd2;

	// result status codes
	localparam code_t ST_DONE  = 2'd0;
	localparam code_t ST_FULL  = 2'd1;
	localparam code_t ST_EMPTY = 2'd2;

	localparam word_t THRESHOLD_RESET = 32'sd60;

	// read address sources (offsets from the head)
	typedef enum logic [1:0] {
		RD_HEAD,
		RD_SCAN,
		RD_SHIFT
	} rd_src_t;

	// write address and data sources
	typedef enum logic [1:0] {
		WR_TAIL,
		WR_SHIFT,
		WR_POS
	} wr_src_t;

	// controller to datapath commands
	typedef struct packed {
		logic    load_req;
		logic    rd_en;
		rd_src_t rd_src;
		logic    wr_en;
		wr_src_t wr_src;
		logic    cnt_inc;
		logic    pop;
		logic    scan_inc;
		logic    shift_init;
		logic    shift_dec;
		logic    out_ld;
		code_t   out_status;
		logic    out_from_mem;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic is_enq;
		logic is_prio;
		logic is_deq;
		logic val_hi;
		logic full;
		logic empty;
		logic rd_hi;
		logic scan_last;
		logic shift_last;
	} sts_t;

endpackage

// File: design/tcpq_req_if.sv
interface tcpq_req_if
	import tcpq_pkg::*;
;
	logic  valid;
	logic  ready;
	code_t req_type;
	word_t in_value;

	modport source (output valid, output req_type, output in_value, input ready);
	modport sink (input valid, input req_type, input in_value, output ready);
endinterface

// File: design/tcpq_rsp_if.sv
interface tcpq_rsp_if
	import tcpq_pkg::*;
;
	logic  valid;
	logic  ready;
	code_t status;
	word_t out_value;

	modport source (output valid, output status, output out_value, input ready);
	modport sink (input valid, input status, input out_value, output ready);
endinterface

// File: design/tcpq_cfg_if.sv
interface tcpq_cfg_if
	import tcpq_pkg::*;
;
	logic  valid;
	logic  ready;
	word_t priority_threshold;

	modport source (output valid, output priority_threshold, input ready);
	modport sink (input valid, input priority_threshold, output ready);
endinterface

// File: design/tcpq_datapath.sv
`include "two_class_priority_queue_unit_macros.svh"

module tcpq_datapath
	import tcpq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic  clk,
	input  logic  arst_n,
	input  cmd_t  cmd,
	output sts_t  sts,
	input  code_t req_type,
	input  word_t in_value,
	input  logic  cfg_wr,
	input  word_t cfg_data,
	output code_t out_status,
	output word_t out_value
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [AW:0]   DEPTH_W = (AW + 1)'(QUEUE_DEPTH);
	localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
	localparam logic [AW-1:0] LAST_A  = AW'(QUEUE_DEPTH - 1);

	code_t          req_type_q;
	word_t          in_value_q;
	word_t          threshold_q;
	logic [CW-1:0]  count_q;
	logic [AW-1:0]  head_q;
	logic [CW-1:0]  scan_q;
	logic [CW-1:0]  shift_k_q;
	word_t          mem [QUEUE_DEPTH];
	word_t          rdata_q;
	code_t          out_status_q;
	word_t          out_value_q;

	logic [CW-1:0]  rd_off;
	logic [CW-1:0]  wr_off;
	logic [AW-1:0]  raddr;
	logic [AW-1:0]  waddr;
	word_t          wdata;

	// offset from head to ring address, one compare and subtract
	function automatic logic [AW-1:0] ring_addr(input logic [AW-1:0] head,
		input logic [CW-1:0] off);
		logic [AW:0] sum;
		sum = {1'b0, head} + {1'b0, off[AW-1:0]};
		if (sum >= DEPTH_W) begin
			sum = sum - DEPTH_W;
		end
		return sum[AW-1:0];
	endfunction

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_type_q <= req_type;
			in_value_q <= in_value;
		end
	end

	// threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RESET;
		end else if (cfg_wr) begin
			threshold_q <= cfg_data;
		end
	end

	// fill count and head pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			head_q  <= '0;
		end else if (cmd.cnt_inc) begin
			count_q <= count_q + CW'(1);
		end else if (cmd.pop) begin
			count_q <= count_q - CW'(1);
			head_q  <= (head_q == LAST_A) ? '0 : head_q + AW'(1);
		end
	end

	// scan position and shift index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q    <= '0;
			shift_k_q <= '0;
		end else begin
			if (cmd.load_req) begin
				scan_q <= '0;
			end else if (cmd.scan_inc) begin
				scan_q <= scan_q + CW'(1);
			end
			if (cmd.shift_init) begin
				shift_k_q <= count_q;
			end else if (cmd.shift_dec) begin
				shift_k_q <= shift_k_q - CW'(1);
			end
		end
	end

	// address and data selection
	always_comb begin
		unique case (cmd.rd_src)
			RD_SCAN:  rd_off = scan_q;
			RD_SHIFT: rd_off = shift_k_q - CW'(1);
			default:  rd_off = '0;
		endcase
		unique case (cmd.wr_src)
			WR_SHIFT: begin
				wr_off = shift_k_q;
				wdata  = rdata_q;
			end
			WR_POS: begin
				wr_off = scan_q;
				wdata  = in_value_q;
			end
			default: begin
				wr_off = count_q;
				wdata  = in_value_q;
			end
		endcase
		raddr = ring_addr(head_q, rd_off);
		waddr = ring_addr(head_q, wr_off);
	end

	// entry storage, registered read
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[waddr] <= wdata;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem[raddr];
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			out_status_q <= cmd.out_status;
			out_value_q  <= cmd.out_from_mem ? rdata_q : '0;
		end
	end

	assign out_status = out_status_q;
	assign out_value  = out_value_q;

	// status towards the controller
	always_comb begin
		sts.is_enq     = (req_type_q == REQ_ENQ) || (req_type_q == REQ_PRIO);
		sts.is_prio    = (req_type_q == REQ_PRIO);
		sts.is_deq     = (req_type_q == REQ_DEQ);
		sts.val_hi     = (in_value_q >= threshold_q);
		sts.full       = (count_q == DEPTH_C);
		sts.empty      = (count_q == '0);
		sts.rd_hi      = (rdata_q >= threshold_q);
		sts.scan_last  = ((scan_q + CW'(1)) == count_q);
		sts.shift_last = (shift_k_q == (scan_q + CW'(1)));
	end

	`TCPQ_ASSERT(a_inc_not_full, clk, arst_n, cmd.cnt_inc |-> (count_q < DEPTH_C), "growth when full")
	`TCPQ_ASSERT(a_pop_not_empty, clk, arst_n, cmd.pop |-> (count_q != '0), "pop when empty")
	`TCPQ_ASSERT(a_shift_above_pos, clk, arst_n,
		(cmd.wr_en && (cmd.wr_src == WR_SHIFT)) |-> (shift_k_q > scan_q), "shift below position")

endmodule

// File: design/tcpq_ctrl.sv
`include "two_class_priority_queue_unit_macros.svh"

module tcpq_ctrl
	import tcpq_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	output logic rsp_valid,
	input  logic rsp_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [3:0] S_IDLE      = 4'd0;
	localparam logic [3:0] S_DECODE    = 4'd1;
	localparam logic [3:0] S_DQ_WAIT   = 4'd2;
	localparam logic [3:0] S_SCAN_RD   = 4'd3;
	localparam logic [3:0] S_SCAN_CHK  = 4'd4;
	localparam logic [3:0] S_SHIFT_RD  = 4'd5;
	localparam logic [3:0] S_SHIFT_WR  = 4'd6;
	localparam logic [3:0] S_INSERT    = 4'd7;
	localparam logic [3:0] S_FINISH    = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_nx;
	code_t      res_code_q;
	code_t      res_code_nx;
	logic       res_mem_q;
	logic       res_mem_nx;
	logic       out_valid_q;

	// next state and command decode
	always_comb begin
		state_nx    = state_q;
		res_code_nx = res_code_q;
		res_mem_nx  = res_mem_q;
		cmd         = '0;
		req_ready   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load_req = 1'b1;
					state_nx     = S_DECODE;
				end
			end
			S_DECODE: begin
				res_code_nx = ST_DONE;
				res_mem_nx  = 1'b0;
				state_nx    = S_FINISH;
				// unused request code falls through with nothing to do
				if (sts.is_enq) begin
					priority if (sts.full) begin
						res_code_nx = ST_FULL;
					end else if (sts.is_prio && sts.val_hi) begin
						state_nx = sts.empty ? S_INSERT : S_SCAN_RD;
					end else begin
						cmd.wr_en   = 1'b1;
						cmd.wr_src  = WR_TAIL;
						cmd.cnt_inc = 1'b1;
					end
				end else if (sts.is_deq) begin
					if (sts.empty) begin
						res_code_nx = ST_EMPTY;
					end else begin
						cmd.rd_en  = 1'b1;
						cmd.rd_src = RD_HEAD;
						state_nx   = S_DQ_WAIT;
					end
				end
			end
			S_DQ_WAIT: begin
				cmd.pop    = 1'b1;
				res_mem_nx = 1'b1;
				state_nx   = S_FINISH;
			end
			S_SCAN_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_src = RD_SCAN;
				state_nx   = S_SCAN_CHK;
			end
			S_SCAN_CHK: begin
				// leading run continues, or ends at the tail
				if (sts.rd_hi) begin
					if (sts.scan_last) begin
						cmd.wr_en   = 1'b1;
						cmd.wr_src  = WR_TAIL;
						cmd.cnt_inc = 1'b1;
						state_nx    = S_FINISH;
					end else begin
						cmd.scan_inc = 1'b1;
						state_nx     = S_SCAN_RD;
					end
				end else begin
					cmd.shift_init = 1'b1;
					state_nx       = S_SHIFT_RD;
				end
			end
			S_SHIFT_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_src = RD_SHIFT;
				state_nx   = S_SHIFT_WR;
			end
			S_SHIFT_WR: begin
				cmd.wr_en     = 1'b1;
				cmd.wr_src    = WR_SHIFT;
				cmd.shift_dec = 1'b1;
				state_nx      = sts.shift_last ? S_INSERT : S_SHIFT_RD;
			end
			S_INSERT: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_src  = WR_POS;
				cmd.cnt_inc = 1'b1;
				state_nx    = S_FINISH;
			end
			S_FINISH: begin
				// load the result register once it is free
				if (!out_valid_q || rsp_ready) begin
					cmd.out_ld       = 1'b1;
					cmd.out_status   = res_code_q;
					cmd.out_from_mem = res_mem_q;
					state_nx         = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	// state and result bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_code_q  <= ST_DONE;
			res_mem_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_nx;
			res_code_q <= res_code_nx;
			res_mem_q  <= res_mem_nx;
			if (cmd.out_ld) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = out_valid_q;

	`TCPQ_ASSERT(a_accept_decodes, clk, arst_n,
		(req_valid && req_ready) |=> (state_q == S_DECODE), "accepted request not decoded")
	`TCPQ_ASSERT_NEVER(a_no_overwrite, clk, arst_n, cmd.out_ld && out_valid_q && !rsp_ready,
		"result overwritten before transfer")
	`TCPQ_ASSERT(a_ld_sets_valid, clk, arst_n, cmd.out_ld |=> rsp_valid, "loaded result not shown")
	`TCPQ_ASSERT_NEVER(a_one_mem_op, clk, arst_n, cmd.cnt_inc && cmd.pop, "grow and pop together")

endmodule

// File: design/two_class_priority_queue_unit.sv
// two-class priority queue
// requests arrive on req (valid/ready, req_type and in_value), results leave on rsp
// (valid/ready, status and out_value), and the threshold is written on cfg, which
// is always ready. exactly one result follows every request, in request order.
// one request is worked on at a time; req is ready only while the controller idles.
// steps from a request transfer to its result:
//   plain enqueue, flagged requests and unused codes: decode, then finish
//   dequeue: decode, a registered read of the head, then finish
//   priority enqueue at or above threshold: decode, a read and a compare for each
//   of s entries scanned from the head, a read and a write for each of m entries
//   moved up one place, then insert and finish, or append and finish when the
//   leading run reaches the tail; s and m are both bounded by the fill level
// with the receiver ready the next request is taken at the first edge at which
// the result can transfer, so a request occupies the block only until then.
// the entry ram has a registered read: each scan step and each moved entry is
// one registered read followed by a compare or a write, in separate states.
// the result sits in an output register; a new request is taken while it waits,
// and when the receiver stalls the next result holds in the controller until the
// register frees, so nothing is lost or repeated.
// reset empties the queue and sets the threshold to 60; the ram needs no clearing.
module two_class_priority_queue_unit
	import tcpq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16
) (
	input logic         clk,
	input logic         arst_n,
	tcpq_req_if.sink    req,
	tcpq_rsp_if.source  rsp,
	tcpq_cfg_if.sink    cfg
);

	cmd_t cmd;
	sts_t sts;

	// threshold writes are always taken
	assign cfg.ready = 1'b1;

	tcpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	tcpq_datapath #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.req_type   (req.req_type),
		.in_value   (req.in_value),
		.cfg_wr     (cfg.valid),
		.cfg_data   (cfg.priority_threshold),
		.out_status (rsp.status),
		.out_value  (rsp.out_value)
	);

endmodule
